### hdl/whpc_pkg.sv
// ----------------------------------------------------------------------------
// whpc_pkg
// Shared types and constants of the weighted Hamming pattern classifier:
// field widths, command and register codes, request and result items, and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package whpc_pkg;

    // Field widths of the request and result items.
    localparam int CMD_W      = 2;
    localparam int NUM_W      = 6;
    localparam int WFIELD_W   = 16;
    localparam int BITS_W     = 64;
    localparam int DEV_W      = 22;
    localparam int BEST_W     = 7;
    localparam int COUNT_W    = 7;
    localparam int SEED_W     = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Request command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD_WEIGHTS = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_PATTERN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLASSIFY     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIE_SEED      = 2'd2;

    // Reset values of the configuration registers and the tie-break LFSR.
    localparam logic [COUNT_W-1:0] ITEM_COUNT_RST    = 7'd64;
    localparam logic [COUNT_W-1:0] PATTERN_COUNT_RST = 7'd64;
    localparam logic [SEED_W-1:0]  TIE_SEED_RST      = 16'd44257;
    localparam logic [SEED_W-1:0]  LFSR_TAPS         = 16'hB400;

    // The running minimum starts one above the largest deviation.
    localparam logic [DEV_W:0]     MIN_START         = {1'b1, {DEV_W{1'b0}}};

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [NUM_W-1:0]    item_number;
        logic [WFIELD_W-1:0] guess_weight;
        logic [WFIELD_W-1:0] slip_weight;
        logic [NUM_W-1:0]    pattern_number;
        logic [BITS_W-1:0]   pattern_bits;
        logic [BITS_W-1:0]   response_bits;
        logic [BITS_W-1:0]   observed_mask;
    } req_item_t;

    typedef struct packed {
        logic [NUM_W-1:0]  pattern_index;
        logic [DEV_W-1:0]  deviation;
        logic              is_last;
        logic [BEST_W-1:0] best_index;
        logic [DEV_W-1:0]  best_deviation;
    } rsp_item_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;     // accepted request, write the tables if it is a load
        logic start;    // accepted classify request, latch person and reset minimum
        logic fetch;    // read the pattern row, clear the sum
        logic sum;      // add the weight of the current item
        logic update;   // fold the sum into the minimum, load the result
        logic advance;  // move to the next pattern
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic items_zero;
        logic item_last;
        logic pat_last;
    } dp_status_t;

endpackage

`default_nettype wire

### hdl/whpc_stream_if.sv
// ----------------------------------------------------------------------------
// whpc_stream_if
// Valid/ready channel carrying one payload item per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface whpc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hdl/weighted_hamming_pattern_classifier.sv
// ----------------------------------------------------------------------------
// weighted_hamming_pattern_classifier
// Nearest stored pattern by weighted Hamming distance, with per-item guess
// and slip weights and an LFSR tie-break on the running minimum.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Contents
//  --------+-----------+--------------------+--------------------------------
//  req     | in        | valid / ready      | load weights, load row, classify
//  rsp     | out       | valid / ready      | one deviation per pattern
//  cfg     | in        | cfg_we, no wait    | item_count, pattern_count, seed
//
//  A load request is taken and written in the idle state. A classify
//  request is taken there too; then, for each pattern in use, the
//  sequencer reads the pattern row, adds the weight of each item in use in
//  the weight accumulator (the weight RAM gives one item per cycle),
//  updates the minimum and hands the result to the output channel.
//  Requests are taken only when no classification runs; a stalled result
//  holds the sequencer. Reset restores the configuration and the LFSR seed;
//  the tables hold no meaning until written.
//
`default_nettype none

module weighted_hamming_pattern_classifier #(
    parameter int MAX_ITEMS    = 64,
    parameter int MAX_PATTERNS = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    whpc_stream_if.sink                           req,
    whpc_stream_if.source                         rsp,
    input  wire logic                             cfg_we,
    input  wire logic [whpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [whpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import whpc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    req_item_t  req_item;
    rsp_item_t  rsp_item;
    logic       req_ready;
    logic       rsp_valid;

    assign req_item    = req.payload;
    assign req.ready   = req_ready;
    assign rsp.valid   = rsp_valid;
    assign rsp.payload = rsp_item;

    // Sequencer.
    whpc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_command (req_item.command),
        .req_ready   (req_ready),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp.ready),
        .cmd         (cmd),
        .status      (status)
    );

    // Tables, accumulator and minimum search.
    whpc_datapath #(
        .MAX_ITEMS    (MAX_ITEMS),
        .MAX_PATTERNS (MAX_PATTERNS),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_item  (req_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_item  (rsp_item)
    );

    // No request is taken while a result is offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !rsp_valid)
        else $error("request taken while a result is pending");

    // The final result of a run returns the block to taking requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.ready && rsp_item.is_last) |=> req_ready)
        else $error("block did not return to idle after the last result");

    // The reported minimum never exceeds the deviation of the last pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_item.is_last) |->
            (rsp_item.best_deviation <= rsp_item.deviation))
        else $error("best deviation above the last deviation");

endmodule

`default_nettype wire

### hdl/whpc_ram.sv
// ----------------------------------------------------------------------------
// whpc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module whpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hdl/whpc_ctrl.sv
// ----------------------------------------------------------------------------
// whpc_ctrl
// Sequencer of the classifier: takes requests, walks patterns and items,
// and hands each result to the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module whpc_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    input  wire logic [whpc_pkg::CMD_W-1:0]  req_command,
    output logic                             req_ready,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output whpc_pkg::ctrl_cmd_t              cmd,
    input  wire whpc_pkg::dp_status_t        status
);

    import whpc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_FETCH  = 5'b00010,
        S_SUM    = 5'b00100,
        S_UPDATE = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        req_ready   = 1'b0;
        rsp_valid   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    if (req_command == CMD_CLASSIFY)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = status.items_zero ? S_UPDATE : S_SUM;
            end
            S_SUM:
            begin
                cmd.sum = 1'b1;
                if (status.item_last)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    if (status.pat_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/whpc_datapath.sv
// ----------------------------------------------------------------------------
// whpc_datapath
// Tables, configuration registers, weighted mismatch accumulator, running
// minimum with LFSR tie-break, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module whpc_datapath #(
    parameter int MAX_ITEMS    = 64,
    parameter int MAX_PATTERNS = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire whpc_pkg::ctrl_cmd_t              cmd,
    output whpc_pkg::dp_status_t                  status,
    input  wire whpc_pkg::req_item_t              req_item,
    input  wire logic                             cfg_we,
    input  wire logic [whpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [whpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output whpc_pkg::rsp_item_t                   rsp_item
);

    import whpc_pkg::*;

    localparam int IAW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int ICW = $clog2(MAX_ITEMS + 1);
    localparam int PAW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int PCW = $clog2(MAX_PATTERNS + 1);
    localparam int WW  = 2 * WEIGHT_BITS;

    // Configuration and tie-break state.
    logic [COUNT_W-1:0]   item_count_reg;
    logic [COUNT_W-1:0]   pattern_count_reg;
    logic [SEED_W-1:0]    lfsr_reg;
    logic [SEED_W-1:0]    lfsr_next;

    // Classification state.
    logic [MAX_ITEMS-1:0] resp_reg;
    logic [MAX_ITEMS-1:0] mask_reg;
    logic [PCW-1:0]       p_reg;
    logic [ICW-1:0]       i_reg;
    logic [ICW-1:0]       i_next;
    logic [DEV_W-1:0]     acc_reg;
    logic [DEV_W:0]       best_reg;
    logic [PCW-1:0]       best_idx_reg;
    rsp_item_t            out_reg;

    // Table ports.
    logic                 weight_we;
    logic                 pattern_we;
    logic [WW-1:0]        weight_rd;
    logic [MAX_ITEMS-1:0] pattern_rd;

    // Derived values.
    logic [ICW-1:0]         n_items;
    logic [PCW-1:0]         n_patterns;
    logic [WEIGHT_BITS-1:0] guess_w;
    logic [WEIGHT_BITS-1:0] slip_w;
    logic                   obs_bit;
    logic                   pat_bit;
    logic                   resp_bit;
    logic [DEV_W-1:0]       add_w;
    logic [DEV_W:0]         dev_ext;
    logic                   dev_less;
    logic                   dev_le;
    logic [DEV_W:0]         best_new;
    logic [PCW-1:0]         idx_new;

    // Items and patterns in use, saturated to the table sizes; a pattern count of zero counts as one.
    always_comb
    begin
        if (int'(item_count_reg) > MAX_ITEMS)
        begin
            n_items = ICW'(MAX_ITEMS);
        end
        else
        begin
            n_items = ICW'(item_count_reg);
        end

        if (pattern_count_reg == '0)
        begin
            n_patterns = PCW'(1);
        end
        else if (int'(pattern_count_reg) > MAX_PATTERNS)
        begin
            n_patterns = PCW'(MAX_PATTERNS);
        end
        else
        begin
            n_patterns = PCW'(pattern_count_reg);
        end
    end

    assign status.items_zero = (item_count_reg == '0);
    assign status.item_last  = (ICW'(i_reg + ICW'(1)) == n_items);
    assign status.pat_last   = (PCW'(p_reg + PCW'(1)) == n_patterns);

    // Table writes on load requests, within the table bounds.
    assign weight_we  = cmd.load && (req_item.command == CMD_LOAD_WEIGHTS)
                        && (int'(req_item.item_number) < MAX_ITEMS);
    assign pattern_we = cmd.load && (req_item.command == CMD_LOAD_PATTERN)
                        && (int'(req_item.pattern_number) < MAX_PATTERNS);

    // The weight read address runs one item ahead of the sum.
    assign i_next = cmd.fetch ? '0 : ICW'(i_reg + ICW'(1));

    whpc_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_ITEMS)
    ) u_weight_ram (
        .clk     (clk),
        .wr_en   (weight_we),
        .wr_addr (IAW'(req_item.item_number)),
        .wr_data ({WEIGHT_BITS'(req_item.slip_weight), WEIGHT_BITS'(req_item.guess_weight)}),
        .rd_en   (cmd.fetch || cmd.sum),
        .rd_addr (IAW'(i_next)),
        .rd_data (weight_rd)
    );

    whpc_ram #(
        .WIDTH (MAX_ITEMS),
        .DEPTH (MAX_PATTERNS)
    ) u_pattern_ram (
        .clk     (clk),
        .wr_en   (pattern_we),
        .wr_addr (PAW'(req_item.pattern_number)),
        .wr_data (MAX_ITEMS'(req_item.pattern_bits)),
        .rd_en   (cmd.fetch),
        .rd_addr (PAW'(p_reg)),
        .rd_data (pattern_rd)
    );

    // Weight picked for the current item: slip, guess or nothing.
    always_comb
    begin
        guess_w  = weight_rd[WEIGHT_BITS-1:0];
        slip_w   = weight_rd[WW-1:WEIGHT_BITS];
        obs_bit  = mask_reg[i_reg[IAW-1:0]];
        pat_bit  = pattern_rd[i_reg[IAW-1:0]];
        resp_bit = resp_reg[i_reg[IAW-1:0]];
        if (obs_bit && pat_bit && !resp_bit)
        begin
            add_w = DEV_W'(slip_w);
        end
        else if (obs_bit && !pat_bit && resp_bit)
        begin
            add_w = DEV_W'(guess_w);
        end
        else
        begin
            add_w = '0;
        end
    end

    // Running minimum and coin toss whenever the sum meets the minimum.
    always_comb
    begin
        dev_ext   = {1'b0, acc_reg};
        dev_less  = (dev_ext < best_reg);
        dev_le    = (dev_ext <= best_reg);
        best_new  = dev_less ? dev_ext : best_reg;
        idx_new   = (dev_less || (dev_le && lfsr_reg[0]))
                    ? PCW'(p_reg + PCW'(1)) : best_idx_reg;
        lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
    end

    // Configuration registers and the LFSR.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg    <= ITEM_COUNT_RST;
            pattern_count_reg <= PATTERN_COUNT_RST;
            lfsr_reg          <= TIE_SEED_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ITEM_COUNT:
                    begin
                        item_count_reg <= COUNT_W'(cfg_data);
                    end
                    CFG_PATTERN_COUNT:
                    begin
                        pattern_count_reg <= COUNT_W'(cfg_data);
                    end
                    CFG_TIE_SEED:
                    begin
                        // A zero seed would lock the LFSR, so it loads one.
                        lfsr_reg <= (SEED_W'(cfg_data) == '0) ? SEED_W'(1) : SEED_W'(cfg_data);
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (cmd.update && dev_le)
            begin
                lfsr_reg <= lfsr_next;
            end
        end
    end

    // Pattern and item counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= '0;
            i_reg <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                p_reg <= '0;
            end
            else if (cmd.advance)
            begin
                p_reg <= PCW'(p_reg + PCW'(1));
            end
            if (cmd.fetch || cmd.sum)
            begin
                i_reg <= i_next;
            end
        end
    end

    // Person bits, sum, minimum and the result register.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            resp_reg     <= MAX_ITEMS'(req_item.response_bits);
            mask_reg     <= MAX_ITEMS'(req_item.observed_mask);
            best_reg     <= MIN_START;
            best_idx_reg <= '0;
        end
        if (cmd.fetch)
        begin
            acc_reg <= '0;
        end
        else if (cmd.sum)
        begin
            acc_reg <= acc_reg + add_w;
        end
        if (cmd.update)
        begin
            best_reg               <= best_new;
            best_idx_reg           <= idx_new;
            out_reg.pattern_index  <= NUM_W'(p_reg);
            out_reg.deviation      <= acc_reg;
            out_reg.is_last        <= status.pat_last;
            out_reg.best_index     <= status.pat_last ? BEST_W'(idx_new) : '0;
            out_reg.best_deviation <= status.pat_last ? DEV_W'(best_new) : '0;
        end
    end

    assign rsp_item = out_reg;

endmodule

`default_nettype wire
